FILE: hw/rtl/kss_pkg.sv
// Shared types, codes and defaults for the KMP substring search block.
`default_nettype none

package kss_pkg;

    // Default sizing
    localparam int PATTERN_MAX_DEF   = 64;
    localparam int POSITION_BITS_DEF = 16;
    localparam int MATCH_POS_W       = 16;

    // Request command codes
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_NONE   = 2'd3
    } kss_cmd_t;

    // Response status codes
    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_DROPPED   = 3'd1,
        STAT_SEARCHING = 3'd2,
        STAT_MATCH     = 3'd3,
        STAT_NOT_FOUND = 3'd4,
        STAT_ALREADY   = 3'd5,
        STAT_OVERFLOW  = 3'd6
    } kss_status_t;

    // Controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } kss_state_t;

    typedef struct packed {
        kss_cmd_t    command;
        logic [7:0]  data_byte;
        logic        last_of_text;
    } kss_req_t;

    typedef struct packed {
        kss_status_t             status;
        logic [MATCH_POS_W-1:0]  match_position;
    } kss_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kss_stream_if.sv
// Valid/ready stream channel carrying one payload per request.
`default_nettype none

interface kss_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/kmp_substring_search.sv
// Streaming KMP substring search: pattern/failure memories and walk controller.
//
// Usage:
//   req (sink) takes one request per handshake: command, data_byte, last_of_text.
//   Clear empties the pattern, append adds one pattern byte and extends the
//   failure table, text streams one byte of the searched text.
//   rsp (source) gives exactly one response per request, in order: a status
//   code and the start position of the first match.
// Timing:
//   A request is taken in the idle cycle, its memory read is registered, and
//   it is answered from the walk state after any failure links it follows.
//   The links come from the failure memory, one synchronous read
//   per cycle; on average a text byte follows fewer than one link.
//   The response sits in an output register; the next request is taken while
//   it waits. If the previous response is still not taken when the next one
//   is ready, the controller holds until rsp.ready frees the register.
// Reset:
//   rst_n clears pattern length, search state and the response valid flag.
//   The pattern and failure memories are not cleared; only entries below the
//   pattern length are ever used, so no clearing pass is needed.
`default_nettype none

module kmp_substring_search #(
    parameter int PATTERN_MAX   = kss_pkg::PATTERN_MAX_DEF,
    parameter int POSITION_BITS = kss_pkg::POSITION_BITS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    kss_stream_if.sink   req,
    kss_stream_if.source rsp
);
    import kss_pkg::*;

    localparam int IW    = $clog2(PATTERN_MAX);
    localparam int CW    = $clog2(PATTERN_MAX + 1);
    localparam int PB    = POSITION_BITS;
    localparam int EXT_W = (PB > MATCH_POS_W) ? PB : MATCH_POS_W;

    // Control and search state
    kss_state_t       state_reg,      state_next;
    kss_cmd_t         cmd_reg,        cmd_next;
    logic [7:0]       byte_reg,       byte_next;
    logic             last_reg,       last_next;
    logic [IW-1:0]    walk_reg,       walk_next;
    logic [CW-1:0]    count_reg,      count_next;
    logic [IW-1:0]    prefix_reg,     prefix_next;
    logic [IW-1:0]    matched_reg,    matched_next;
    logic [PB-1:0]    text_pos_reg,   text_pos_next;
    logic             found_reg,      found_next;
    logic [PB-1:0]    found_pos_reg,  found_pos_next;
    logic             rsp_valid_reg,  rsp_valid_next;
    kss_rsp_t         rsp_data_reg,   rsp_data_next;

    // Pattern and failure memories
    logic [7:0]       pat_mem  [PATTERN_MAX];
    logic [IW-1:0]    fail_mem [PATTERN_MAX];
    logic [7:0]       pat_rd_reg;
    logic [IW-1:0]    fail_rd_reg;
    logic [IW-1:0]    rd_addr;
    logic [IW-1:0]    fail_addr;
    logic             mem_we;
    logic [IW-1:0]    wr_addr;
    logic [IW-1:0]    wr_fail;

    // Walk datapath
    logic             out_free;
    logic             hit;
    logic             walk_needed;
    logic             step;
    logic             full;
    logic             pos_sat;
    logic [IW-1:0]    border_fin;
    logic [CW-1:0]    text_len;
    logic             text_match;
    logic [PB-1:0]    new_found_pos;
    logic [EXT_W-1:0] found_ext;
    logic [EXT_W-1:0] new_found_ext;

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    assign out_free      = !rsp_valid_reg || rsp.ready;
    assign hit           = (pat_rd_reg == byte_reg);
    assign full          = (count_reg == CW'(PATTERN_MAX));
    assign pos_sat       = (text_pos_reg == {PB{1'b1}});
    assign fail_addr     = rd_addr - IW'(1);
    assign border_fin    = walk_reg + IW'(hit && (count_reg != '0));
    assign text_len      = CW'(walk_reg) + CW'(hit);
    assign text_match    = (text_len == count_reg);
    assign new_found_pos = text_pos_reg + PB'(1) - PB'(count_reg);
    assign found_ext     = EXT_W'(found_pos_reg);
    assign new_found_ext = EXT_W'(new_found_pos);
    assign wr_addr       = count_reg[IW-1:0];
    assign wr_fail       = border_fin;

    // Does this request follow failure links at all
    always_comb
    begin
        unique case (cmd_reg)
            CMD_APPEND: walk_needed = !full && (count_reg != '0);
            CMD_TEXT:   walk_needed = !found_reg && !pos_sat && (count_reg != '0);
            default:    walk_needed = 1'b0;
        endcase
    end

    assign step = (state_reg == S_WALK) && walk_needed && (walk_reg != '0) && !hit;

    // Next state, memory control and response
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        walk_next      = walk_reg;
        count_next     = count_reg;
        prefix_next    = prefix_reg;
        matched_next   = matched_reg;
        text_pos_next  = text_pos_reg;
        found_next     = found_reg;
        found_pos_next = found_pos_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_data_next  = rsp_data_reg;
        mem_we         = 1'b0;
        rd_addr        = walk_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = (req.payload.command == CMD_APPEND) ? prefix_reg : matched_reg;
                if (req.valid)
                begin
                    cmd_next   = req.payload.command;
                    byte_next  = req.payload.data_byte;
                    last_next  = req.payload.last_of_text;
                    walk_next  = rd_addr;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (step)
                begin
                    // follow one failure link
                    rd_addr   = fail_rd_reg;
                    walk_next = fail_rd_reg;
                end
                else if (out_free)
                begin
                    rsp_valid_next               = 1'b1;
                    rsp_data_next.status         = STAT_OK;
                    rsp_data_next.match_position = '0;
                    state_next                   = S_IDLE;
                    unique case (cmd_reg)
                        CMD_CLEAR:
                        begin
                            count_next     = '0;
                            prefix_next    = '0;
                            matched_next   = '0;
                            text_pos_next  = '0;
                            found_next     = 1'b0;
                            found_pos_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (full)
                            begin
                                rsp_data_next.status = STAT_DROPPED;
                            end
                            else
                            begin
                                mem_we         = 1'b1;
                                prefix_next    = border_fin;
                                count_next     = count_reg + CW'(1);
                                matched_next   = '0;
                                text_pos_next  = '0;
                                found_next     = 1'b0;
                                found_pos_next = '0;
                            end
                        end
                        CMD_TEXT:
                        begin
                            priority if (found_reg)
                            begin
                                rsp_data_next.status         = STAT_ALREADY;
                                rsp_data_next.match_position = found_ext[MATCH_POS_W-1:0];
                            end
                            else if (pos_sat)
                            begin
                                rsp_data_next.status = STAT_OVERFLOW;
                            end
                            else if (count_reg == '0)
                            begin
                                found_next           = 1'b1;
                                found_pos_next       = '0;
                                rsp_data_next.status = STAT_MATCH;
                            end
                            else
                            begin
                                text_pos_next = text_pos_reg + PB'(1);
                                if (text_match)
                                begin
                                    found_next     = 1'b1;
                                    found_pos_next = new_found_pos;
                                    matched_next   = '0;
                                    rsp_data_next.status = STAT_MATCH;
                                    rsp_data_next.match_position =
                                        new_found_ext[MATCH_POS_W-1:0];
                                end
                                else
                                begin
                                    matched_next = text_len[IW-1:0];
                                    rsp_data_next.status =
                                        last_reg ? STAT_NOT_FOUND : STAT_SEARCHING;
                                end
                            end
                            // end of text: drop search state, keep pattern
                            if (last_reg)
                            begin
                                matched_next   = '0;
                                text_pos_next  = '0;
                                found_next     = 1'b0;
                                found_pos_next = '0;
                            end
                        end
                        CMD_NONE:
                        begin
                        end
                    endcase
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            prefix_reg    <= '0;
            matched_reg   <= '0;
            text_pos_reg  <= '0;
            found_reg     <= 1'b0;
            found_pos_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            prefix_reg    <= prefix_next;
            matched_reg   <= matched_next;
            text_pos_reg  <= text_pos_next;
            found_reg     <= found_next;
            found_pos_reg <= found_pos_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Request and response payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        walk_reg     <= walk_next;
        rsp_data_reg <= rsp_data_next;
    end

    // Memories: one write port, registered reads
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pat_mem[wr_addr]  <= byte_reg;
            fail_mem[wr_addr] <= wr_fail;
        end
        pat_rd_reg  <= pat_mem[rd_addr];
        fail_rd_reg <= fail_mem[fail_addr];
    end

`ifndef SYNTH
    localparam int SW = ((PB > CW) ? PB : CW) + 1;

    // Pattern length never passes the memory depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(PATTERN_MAX))
        else $error("pattern length out of range");

    // Partial match is always shorter than the pattern
    a_matched_short: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (CW'(matched_reg) < count_reg))
        else $error("matched length not below pattern length");

    // Border of the pattern is a proper border
    a_prefix_short: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (CW'(prefix_reg) < count_reg))
        else $error("pattern border not proper");

    // Stored match start plus pattern length lands on the text position
    a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg && (count_reg != '0) |->
            (SW'(found_pos_reg) + SW'(count_reg) == SW'(text_pos_reg)))
        else $error("found position inconsistent with text position");

    // A taken request blocks the channel until it is answered
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second request taken while one in flight");
`endif

endmodule

`default_nettype wire
